// ----- src/outlet_test_sequencer_unit_defines.svh -----
// ---------------------------------------------------------------------------
// Outlet test sequencer assertion macros
// Concurrent assertion helpers; they compile away when SYNTHESIS is set.
// ---------------------------------------------------------------------------
`ifndef OUTLET_TEST_SEQUENCER_UNIT_DEFINES_SVH
`define OUTLET_TEST_SEQUENCER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// Checks prop at every rising edge of clk while rst_n is high.
`define OTS_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("outlet test sequencer: assertion failed");
// Checks that a trigger is followed in the next cycle by a consequence.
`define OTS_ASSERT_NEXT(label, clk, rst_n, trig, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
		else $error("outlet test sequencer: assertion failed");
`else
`define OTS_ASSERT(label, clk, rst_n, prop)
`define OTS_ASSERT_NEXT(label, clk, rst_n, trig, cons)
`endif

`endif

// ----- src/ots_pkg.sv -----
// ---------------------------------------------------------------------------
// Outlet test sequencer package
// Shared types, codes and constants of the outlet test sequencer.
// ---------------------------------------------------------------------------
package ots_pkg;

	// Number of outlets that the cycling submodes step through.
	localparam int OUTLET_COUNT = 8;
	localparam int OutletCountEff = (OUTLET_COUNT == 0) ? 1 : OUTLET_COUNT;

	localparam logic OP_TIME_UPDATE  = 1'b0;
	localparam logic OP_NEXT_SUBMODE = 1'b1;

	localparam logic [1:0] SUBMODE_NORM_CLOSED = 2'd0;
	localparam logic [1:0] SUBMODE_NORM_OPEN   = 2'd1;
	localparam logic [1:0] SUBMODE_LIFETIME    = 2'd2;

	localparam logic [1:0] REG_SHORT_HOLD    = 2'd0;
	localparam logic [1:0] REG_LONG_HOLD     = 2'd1;
	localparam logic [1:0] REG_LIFETIME_HOLD = 2'd2;

	localparam logic [15:0] SHORT_HOLD_RESET    = 16'd1500;
	localparam logic [15:0] LONG_HOLD_RESET     = 16'd4500;
	localparam logic [15:0] LIFETIME_HOLD_RESET = 16'd1000;

	typedef struct packed {
		logic        opcode;
		logic [31:0] now_ms;
	} ots_item_t;

	typedef struct packed {
		logic        actuate;
		logic        all_outlets;
		logic [2:0]  outlet_index;
		logic        open_cmd;
		logic [31:0] cycles_done;
		logic [1:0]  active_submode;
	} ots_result_t;

	typedef struct packed {
		logic        started;
		logic [31:0] last_toggle_ms;
		logic        is_open;
		logic [2:0]  outlet_pointer;
		logic [31:0] open_count;
		logic [1:0]  submode;
	} ots_state_t;

	typedef struct packed {
		logic [15:0] short_hold_ms;
		logic [15:0] long_hold_ms;
		logic [15:0] lifetime_hold_ms;
	} ots_cfg_t;

	// Pointer advance modulo the outlet count, kept in three bits.
	function automatic logic [2:0] next_pointer(input logic [2:0] p);
		logic [5:0] sum;
		logic [5:0] wrapped;
		sum = {3'b000, p} + 6'd1;
		wrapped = sum % 6'(OutletCountEff);
		return wrapped[2:0];
	endfunction

endpackage

// ----- src/ots_item_if.sv -----
// ---------------------------------------------------------------------------
// Outlet test sequencer channel interfaces
// Valid/ready channels for input items and for result items.
// ---------------------------------------------------------------------------
interface ots_item_if import ots_pkg::*; ();
	logic      valid;
	logic      ready;
	ots_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface ots_result_if import ots_pkg::*; ();
	logic        valid;
	logic        ready;
	ots_result_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ----- src/ots_step.sv -----
// ---------------------------------------------------------------------------
// Outlet test sequencer step logic
// Next state and actuation flags for one item, from the current state.
// ---------------------------------------------------------------------------
module ots_step import ots_pkg::*; (
	input  ots_state_t  cur,
	input  ots_cfg_t    cfg,
	input  ots_item_t   item,
	output ots_state_t  nxt,
	output logic        act,
	output logic        all
);

	logic [31:0] elapsed;
	logic [15:0] hold;
	logic        due;

	assign elapsed = item.now_ms - cur.last_toggle_ms;

	always_comb begin
		unique case (cur.submode)
			SUBMODE_NORM_CLOSED: hold = cur.is_open ? cfg.short_hold_ms : cfg.long_hold_ms;
			SUBMODE_NORM_OPEN:   hold = cur.is_open ? cfg.long_hold_ms : cfg.short_hold_ms;
			default:             hold = cfg.lifetime_hold_ms;
		endcase
	end

	assign due = (elapsed >= {16'd0, hold});

	always_comb begin
		nxt = cur;
		act = 1'b0;
		all = 1'b0;
		if (item.opcode == OP_NEXT_SUBMODE) begin
			nxt.submode = (cur.submode >= SUBMODE_LIFETIME) ? SUBMODE_NORM_CLOSED
				: cur.submode + 2'd1;
		end else if (!cur.started) begin
			nxt.started        = 1'b1;
			nxt.last_toggle_ms = item.now_ms;
			nxt.is_open        = (cur.submode == SUBMODE_NORM_OPEN);
			nxt.outlet_pointer = 3'd0;
			nxt.open_count     = 32'd0;
			act                = (cur.submode != SUBMODE_LIFETIME);
		end else if (due) begin
			unique case (cur.submode)
				SUBMODE_NORM_CLOSED, SUBMODE_NORM_OPEN: begin
					nxt.last_toggle_ms = item.now_ms;
					nxt.is_open        = !cur.is_open;
					if (!cur.is_open) begin
						nxt.outlet_pointer = next_pointer(cur.outlet_pointer);
					end
					act = 1'b1;
				end
				SUBMODE_LIFETIME: begin
					nxt.last_toggle_ms = item.now_ms;
					nxt.is_open        = !cur.is_open;
					if (!cur.is_open) begin
						nxt.open_count = cur.open_count + 32'd1;
					end
					act = 1'b1;
					all = 1'b1;
				end
				default: begin
					act = 1'b0;
				end
			endcase
		end
	end

endmodule

// ----- src/outlet_test_sequencer_unit.sv -----
// ---------------------------------------------------------------------------
// Outlet test sequencer
// Actuator test pattern generator driven by time updates and submode steps.
// ---------------------------------------------------------------------------
// Every accepted item yields exactly one result item. An item is taken into
// an input register, and from there the step logic (one 32-bit subtract
// and compare of the elapsed time against the selected hold time) updates
// the sequencer state and loads the result register, and the block sustains
// one item per clock cycle while the downstream side takes results. The result
// register holds a finished item while the downstream side stalls, and the
// input register keeps taking items as long as the result can move on.
// The user must write hold times through the configuration port only while
// the block is idle (not enforced); indexes beyond the last register are ignored.
`include "outlet_test_sequencer_unit_defines.svh"

module outlet_test_sequencer_unit import ots_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_write,
	input  logic [1:0]        cfg_index,
	input  logic [15:0]       cfg_data,
	ots_item_if.sink          items,
	ots_result_if.source      results
);

	// Configuration registers.
	ots_cfg_t cfg_q;

	// Input stage.
	logic      valid_s1;
	ots_item_t item_s1;

	// Sequencer state and result register.
	ots_state_t  state_q;
	ots_state_t  state_next;
	logic        out_valid_q;
	ots_result_t result_q;
	logic        step_act;
	logic        step_all;

	// The input stage moves on whenever the result register is free or
	// being emptied in this cycle.
	logic advance;

	assign advance = valid_s1 && (!out_valid_q || results.ready);
	assign items.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.short_hold_ms    <= SHORT_HOLD_RESET;
			cfg_q.long_hold_ms     <= LONG_HOLD_RESET;
			cfg_q.lifetime_hold_ms <= LIFETIME_HOLD_RESET;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_SHORT_HOLD:    cfg_q.short_hold_ms    <= cfg_data;
				REG_LONG_HOLD:     cfg_q.long_hold_ms     <= cfg_data;
				REG_LIFETIME_HOLD: cfg_q.lifetime_hold_ms <= cfg_data;
				default:           cfg_q <= cfg_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (items.ready) begin
			valid_s1 <= items.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (items.ready && items.valid) begin
			item_s1 <= items.data;
		end
	end

	ots_step u_step (
		.cur  (state_q),
		.cfg  (cfg_q),
		.item (item_s1),
		.nxt  (state_next),
		.act  (step_act),
		.all  (step_all)
	);

	// The state is control state here: every field has a defined reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (advance) begin
			state_q <= state_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// The result reports the state as it stands after the item.
	always_ff @(posedge clk) begin
		if (advance) begin
			result_q.actuate        <= step_act;
			result_q.all_outlets    <= step_all;
			result_q.outlet_index   <= state_next.outlet_pointer;
			result_q.open_cmd       <= state_next.is_open;
			result_q.cycles_done    <= state_next.open_count;
			result_q.active_submode <= state_next.submode;
		end
	end

	assign results.valid = out_valid_q;
	assign results.data  = result_q;

	// A command to every outlet is always an actuation.
	`OTS_ASSERT(a_all_needs_act, clk, arst_n, !out_valid_q || result_q.actuate || !result_q.all_outlets)
	// A submode step never actuates anything.
	`OTS_ASSERT_NEXT(a_submode_no_act, clk, arst_n, advance && item_s1.opcode == OP_NEXT_SUBMODE, !result_q.actuate)
	// Once running, the cycle counter moves only in lifetime submode.
	`OTS_ASSERT_NEXT(a_count_lifetime_only, clk, arst_n, advance && state_q.started && state_q.submode != SUBMODE_LIFETIME, $stable(state_q.open_count))
	// The outlet pointer stays inside the outlet range.
	`OTS_ASSERT(a_pointer_range, clk, arst_n, (32'(state_q.outlet_pointer) < 32'(OutletCountEff)) || (OutletCountEff > 8))
	// Nothing is started before the first time update has gone through.
	`OTS_ASSERT_NEXT(a_start_on_update, clk, arst_n, !state_q.started && !advance, !state_q.started)

endmodule

// ----- test/outlet_test_sequencer_unit_test.sv -----
// ---------------------------------------------------------------------------
// Outlet test sequencer testbench
// Drives time updates and submode steps into the sequencer through random
// handshake gaps, predicts every result item from a model of the sequencer
// state and compares each result item field by field, across several hold
// time settings.
// ---------------------------------------------------------------------------
module outlet_test_sequencer_unit_test;
	import ots_pkg::*;

	// Write index that addresses no register; the block must ignore it.
	localparam logic [1:0] REG_UNUSED = 2'd3;
	// Outlet count as the sequencer uses it, with zero treated as one.
	localparam int OUTLET_TOTAL = (OUTLET_COUNT == 0) ? 1 : OUTLET_COUNT;
	// Cycles without any accepted item or result item after which the run is declared hung.
	localparam int STALL_LIMIT = 2000;
	// Length of the deliberate receiver hold-off, in cycles.
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int DIRECTED_LAST_MS = 32'h5555_5555;
	localparam int PHASE_COUNT = 7;
	localparam int ITEMS_PER_PHASE = 170;

	logic        clk;
	logic        arst_n;
	logic        cfg_write;
	logic [1:0]  cfg_index;
	logic [15:0] cfg_data;

	ots_item_if   items_ch ();
	ots_result_if results_ch ();

	outlet_test_sequencer_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.items    (items_ch),
		.results  (results_ch)
	);

	// Model of the sequencer: its state and the hold times as last written.
	ots_state_t seq_state;
	ots_cfg_t   hold_cfg;

	// Items waiting to be offered, front first, and the result items that
	// accepted items have produced but that have not come out yet.
	ots_item_t   sequencer_inputs[$];
	ots_result_t outlet_cmds_due[$];

	// Timestamp of the most recently queued time update.
	logic [31:0] clock_ms;

	// Handshake bookkeeping shared between the driver and the monitors.
	bit offering;
	bit taken;
	int src_gap;
	int snk_gap;
	int hold_left;
	bit hold_off_request;
	bit src_idle_on;
	bit snk_idle_on;
	bit quiet;

	// Run statistics.
	int mismatches;
	int items_in;
	int results_out;
	int single_acts;
	int all_acts;
	int steps_taken;
	int settings_run;

	always #10 clk = ~clk;

	// Advances the model by one item and returns the result item it yields.
	// Submode steps only touch the submode; the first time update starts the
	// sequence; later time updates toggle once the elapsed time (mod 2^32)
	// reaches the hold time that applies to the current submode and state.
	function automatic ots_result_t step_sequencer(input ots_item_t it);
		ots_result_t r;
		logic [31:0] elapsed;
		logic [15:0] hold;
		r = '0;
		if (it.opcode == OP_NEXT_SUBMODE) begin
			seq_state.submode = (seq_state.submode >= SUBMODE_LIFETIME) ?
				SUBMODE_NORM_CLOSED : seq_state.submode + 2'd1;
		end else if (!seq_state.started) begin
			seq_state.started        = 1'b1;
			seq_state.last_toggle_ms = it.now_ms;
			seq_state.is_open        = (seq_state.submode == SUBMODE_NORM_OPEN);
			seq_state.outlet_pointer = 3'd0;
			seq_state.open_count     = 32'd0;
			r.actuate                = (seq_state.submode != SUBMODE_LIFETIME);
		end else begin
			elapsed = it.now_ms - seq_state.last_toggle_ms;
			case (seq_state.submode)
				SUBMODE_NORM_CLOSED, SUBMODE_NORM_OPEN: begin
					// The short hold applies to the open state when normally
					// closed and to the closed state when normally open.
					if ((seq_state.submode == SUBMODE_NORM_CLOSED) == seq_state.is_open)
						hold = hold_cfg.short_hold_ms;
					else
						hold = hold_cfg.long_hold_ms;
					if (elapsed >= 32'(hold)) begin
						seq_state.last_toggle_ms = it.now_ms;
						seq_state.is_open        = !seq_state.is_open;
						if (seq_state.is_open)
							seq_state.outlet_pointer =
								3'((int'(seq_state.outlet_pointer) + 1) % OUTLET_TOTAL);
						r.actuate = 1'b1;
					end
				end
				SUBMODE_LIFETIME: begin
					if (elapsed >= 32'(hold_cfg.lifetime_hold_ms)) begin
						seq_state.last_toggle_ms = it.now_ms;
						seq_state.is_open        = !seq_state.is_open;
						if (seq_state.is_open)
							seq_state.open_count = seq_state.open_count + 32'd1;
						r.actuate     = 1'b1;
						r.all_outlets = 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
		r.outlet_index   = seq_state.outlet_pointer;
		r.open_cmd       = seq_state.is_open;
		r.cycles_done    = seq_state.open_count;
		r.active_submode = seq_state.submode;
		return r;
	endfunction

	function automatic void check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			mismatches++;
		end
	endfunction

	function automatic void push_item(input logic op, input logic [31:0] t);
		ots_item_t it;
		it.opcode = op;
		it.now_ms = t;
		sequencer_inputs.push_back(it);
	endfunction

	// Time step for the next update, sized against one of the current hold
	// times so that toggles, near misses and exact hits all come up often.
	function automatic logic [31:0] pick_step();
		logic [31:0] h;
		case ($urandom_range(0, 2))
			0: h = 32'(hold_cfg.short_hold_ms);
			1: h = 32'(hold_cfg.long_hold_ms);
			default: h = 32'(hold_cfg.lifetime_hold_ms);
		endcase
		case ($urandom_range(0, 4))
			0: return (h == 0) ? 32'd0 : h - 32'd1;
			1: return h;
			2: return h + $urandom_range(1, 40);
			3: return $urandom_range(0, h);
			default: return $urandom_range(0, 3);
		endcase
	endfunction

	// Mostly well-formed time progress with random content, plus occasional
	// submode steps and arbitrary jumps of the timestamp.
	function automatic void queue_random_items(input int n);
		int pick;
		for (int i = 0; i < n; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < 8) begin
				push_item(OP_NEXT_SUBMODE, $urandom());
			end else if (pick < 14) begin
				clock_ms = $urandom();
				push_item(OP_TIME_UPDATE, clock_ms);
			end else begin
				clock_ms = clock_ms + pick_step();
				push_item(OP_TIME_UPDATE, clock_ms);
			end
		end
	endfunction

	// Configuration writes take one cycle each and only happen while the
	// block is idle, so the model's copy can be updated right away.
	task automatic write_hold(input logic [1:0] idx, input logic [15:0] val);
		@(negedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		case (idx)
			REG_SHORT_HOLD:    hold_cfg.short_hold_ms = val;
			REG_LONG_HOLD:     hold_cfg.long_hold_ms = val;
			REG_LIFETIME_HOLD: hold_cfg.lifetime_hold_ms = val;
			default: begin
			end
		endcase
		@(negedge clk);
		cfg_write <= 1'b0;
	endtask

	task automatic wait_drained();
		while (sequencer_inputs.size() != 0 || outlet_cmds_due.size() != 0)
			@(posedge clk);
	endtask

	// Input driver: offers the front pending item and holds it until it is
	// taken. Idle bursts only start between items, never under a live offer.
	always @(negedge clk) begin
		if (taken) begin
			void'(sequencer_inputs.pop_front());
			taken    = 1'b0;
			offering = 1'b0;
		end
		if (!offering) begin
			if (src_gap > 0) begin
				src_gap--;
				items_ch.valid <= 1'b0;
			end else if (src_idle_on && !quiet && $urandom_range(0, 5) == 0) begin
				src_gap = $urandom_range(1, 6) - 1;
				items_ch.valid <= 1'b0;
			end else if (sequencer_inputs.size() != 0) begin
				items_ch.valid <= 1'b1;
				items_ch.data  <= sequencer_inputs[0];
				offering = 1'b1;
			end else begin
				items_ch.valid <= 1'b0;
			end
		end
	end

	// Input monitor: every accepted item advances the model at once, so the
	// expected result items line up in acceptance order.
	always @(posedge clk) begin
		ots_result_t r;
		if (arst_n && items_ch.valid && items_ch.ready) begin
			r = step_sequencer(items_ch.data);
			outlet_cmds_due.push_back(r);
			items_in++;
			if (items_ch.data.opcode == OP_NEXT_SUBMODE)
				steps_taken++;
			if (r.actuate && r.all_outlets)
				all_acts++;
			else if (r.actuate)
				single_acts++;
			taken = 1'b1;
		end
	end

	// Result receiver: random stall bursts, plus one long hold-off that lets
	// the block fill up and push back on its input.
	always @(negedge clk) begin
		if (hold_off_request) begin
			hold_left        = HOLD_OFF_CYCLES;
			hold_off_request = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left--;
			results_ch.ready <= 1'b0;
		end else if (snk_gap > 0) begin
			snk_gap--;
			results_ch.ready <= 1'b0;
		end else if (snk_idle_on && !quiet && $urandom_range(0, 5) == 0) begin
			snk_gap = $urandom_range(1, 6) - 1;
			results_ch.ready <= 1'b0;
		end else begin
			results_ch.ready <= 1'b1;
		end
	end

	// Result monitor: each result item must match the oldest expectation.
	always @(posedge clk) begin
		ots_result_t want;
		ots_result_t got;
		if (arst_n && results_ch.valid && results_ch.ready) begin
			got = results_ch.data;
			results_out++;
			if (outlet_cmds_due.size() == 0) begin
				$error("result item arrived with no item outstanding");
				mismatches++;
			end else begin
				want = outlet_cmds_due.pop_front();
				check_field("actuate", 32'(want.actuate), 32'(got.actuate));
				check_field("all_outlets", 32'(want.all_outlets), 32'(got.all_outlets));
				check_field("outlet_index", 32'(want.outlet_index), 32'(got.outlet_index));
				check_field("open_cmd", 32'(want.open_cmd), 32'(got.open_cmd));
				check_field("cycles_done", want.cycles_done, got.cycles_done);
				check_field("active_submode", 32'(want.active_submode),
					32'(got.active_submode));
			end
		end
	end

	// Watchdog: a run in which nothing moves on either side for too long is
	// hung, whatever the reason.
	always @(posedge clk) begin
		int idle_cycles;
		if ((items_ch.valid && items_ch.ready) || (results_ch.valid && results_ch.ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("timeout: nothing accepted for %0d cycles", STALL_LIMIT);
			$display("[outlet_test_sequencer_unit] ERROR");
			$finish;
		end
	end

	initial begin
		logic [15:0] s_hold;
		logic [15:0] l_hold;
		logic [15:0] f_hold;

		clk              = 1'b0;
		arst_n           = 1'b0;
		cfg_write        = 1'b0;
		cfg_index        = REG_SHORT_HOLD;
		cfg_data         = '0;
		items_ch.valid   = 1'b0;
		items_ch.data    = '0;
		results_ch.ready = 1'b0;
		seq_state        = '0;
		hold_cfg.short_hold_ms    = SHORT_HOLD_RESET;
		hold_cfg.long_hold_ms     = LONG_HOLD_RESET;
		hold_cfg.lifetime_hold_ms = LIFETIME_HOLD_RESET;
		src_idle_on      = 1'b1;
		snk_idle_on      = 1'b1;

		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		settings_run = 1;

		// Directed part at the reset hold times. A submode step before the
		// first time update makes start-up happen normally open, and start-up
		// itself comes at timestamp zero, which must still count as started.
		push_item(OP_NEXT_SUBMODE, 32'hFFFF_FFFF);
		push_item(OP_TIME_UPDATE, 32'd0);
		// One short of the long hold, then exactly on it.
		push_item(OP_TIME_UPDATE, 32'd4499);
		push_item(OP_TIME_UPDATE, 32'd4500);
		// Closed state of normally open uses the short hold; reopening
		// advances the outlet pointer.
		push_item(OP_TIME_UPDATE, 32'd5999);
		push_item(OP_TIME_UPDATE, 32'd6000);
		// Lifetime submode keeps the running state and drives all outlets.
		push_item(OP_NEXT_SUBMODE, 32'd0);
		push_item(OP_TIME_UPDATE, 32'd6999);
		push_item(OP_TIME_UPDATE, 32'd7000);
		push_item(OP_TIME_UPDATE, 32'd8000);
		// Largest timestamp, then a wrap through zero that is exactly one
		// lifetime hold later.
		push_item(OP_TIME_UPDATE, 32'hFFFF_FFFF);
		push_item(OP_TIME_UPDATE, 32'd999);
		// Back to normally closed, with its asymmetric holds.
		push_item(OP_NEXT_SUBMODE, 32'h0000_0000);
		push_item(OP_TIME_UPDATE, 32'd999);
		push_item(OP_TIME_UPDATE, 32'd2499);
		push_item(OP_TIME_UPDATE, 32'd6999);
		// A full round of submode steps returns to normally closed.
		push_item(OP_NEXT_SUBMODE, 32'hAAAA_AAAA);
		push_item(OP_NEXT_SUBMODE, 32'h5555_5555);
		push_item(OP_NEXT_SUBMODE, 32'h0000_0000);
		push_item(OP_TIME_UPDATE, 32'hAAAA_AAAA);
		push_item(OP_TIME_UPDATE, DIRECTED_LAST_MS);
		clock_ms = DIRECTED_LAST_MS;

		// Random phases, each at its own hold setting: smallest, largest,
		// zero (which toggles on every update), a lopsided mix, random values
		// and finally the reset values again with no idling at all.
		for (int p = 0; p < PHASE_COUNT; p++) begin
			wait_drained();
			case (p)
				0: begin
					s_hold = 16'd1;
					l_hold = 16'd1;
					f_hold = 16'd1;
				end
				1: begin
					s_hold = 16'hFFFF;
					l_hold = 16'hFFFF;
					f_hold = 16'hFFFF;
				end
				2: begin
					s_hold = 16'd0;
					l_hold = 16'd0;
					f_hold = 16'd0;
				end
				3: begin
					s_hold = 16'd1;
					l_hold = 16'hFFFF;
					f_hold = 16'd300;
				end
				PHASE_COUNT - 1: begin
					s_hold = SHORT_HOLD_RESET;
					l_hold = LONG_HOLD_RESET;
					f_hold = LIFETIME_HOLD_RESET;
				end
				default: begin
					s_hold = 16'($urandom_range(1, 3000));
					l_hold = 16'($urandom_range(1, 65535));
					f_hold = 16'($urandom_range(1, 3000));
				end
			endcase
			write_hold(REG_SHORT_HOLD, s_hold);
			write_hold(REG_LONG_HOLD, l_hold);
			write_hold(REG_LIFETIME_HOLD, f_hold);
			// The unused index must leave every hold time alone.
			if (p == 2)
				write_hold(REG_UNUSED, 16'hFFFF);
			settings_run++;

			src_idle_on = ($urandom_range(0, 3) != 0);
			snk_idle_on = ($urandom_range(0, 3) != 0);
			quiet = (p == PHASE_COUNT - 1);
			// Start the largest holds just below the wrap point.
			if (p == 1)
				clock_ms = 32'hFFFF_0000;
			queue_random_items(ITEMS_PER_PHASE);
			if (p == 1)
				hold_off_request = 1'b1;
		end

		wait_drained();
		repeat (8) @(posedge clk);

		$display("run covered %0d items and %0d result items over %0d hold settings",
			items_in, results_out, settings_run);
		$display("%0d single-outlet and %0d all-outlet actuations, %0d submode steps",
			single_acts, all_acts, steps_taken);
		if (mismatches == 0 && outlet_cmds_due.size() == 0) begin
			$display("[outlet_test_sequencer_unit] OK");
		end else begin
			$display("[outlet_test_sequencer_unit] ERROR");
		end
		$finish;
	end

endmodule
